[sv/block_bitmap_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Concurrent checks, clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/bba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and the command type of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int NUM_BLOCKS       = 32;
	localparam int FIRST_DATA_BLOCK = 3;
	localparam int MAX_RESULTS      = 32;

	localparam int OP_W   = 2;
	localparam int CNT_FW = 6;   // request_count field
	localparam int BLK_W  = 6;   // block number fields
	localparam int STAT_W = 2;

	localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W  = IDX_W + 1;
	localparam int CALC_W = 8;   // room for block numbers, counts and offsets

	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
	localparam logic [CALC_W-1:0] FDB_C    = CALC_W'(FIRST_DATA_BLOCK);
	localparam logic [CALC_W-1:0] NUMB_C   = CALC_W'(NUM_BLOCKS);
	localparam logic [CALC_W-1:0] MAXR_C   = CALC_W'(MAX_RESULTS);

	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);

	localparam logic [OP_W-1:0] OP_FIND_SCAT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND_CONT = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK      = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_RANGE = 2'd2;

	typedef enum logic [1:0] {
		CMD_FIND,
		CMD_MARK,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              contig;
		logic              count_ok;
		logic [CNT_FW-1:0] count;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic              mark_value;
	} cmd_t;

endpackage

[sv/bba_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_in_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface bba_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [5:0] request_count;
	logic [5:0] first_block;
	logic [5:0] last_block;
	logic       mark_value;

	modport source (
		output valid, op, request_count, first_block, last_block, mark_value,
		input  ready
	);
	modport sink (
		input  valid, op, request_count, first_block, last_block, mark_value,
		output ready
	);
endinterface

[sv/bba_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_out_if
// Result channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface bba_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] block_number;
	logic [1:0] status;
	logic       compacted;
	logic       last_of_run;

	modport source (
		output valid, block_number, status, compacted, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, block_number, status, compacted, last_of_run,
		output ready
	);
endinterface

[sv/bba_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_front
// Takes request words, decodes op and range checks, registers a command.
// ----------------------------------------------------------------------------
module bba_front
	import bba_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bba_in_if.sink        req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output cmd_t          cmd
);

	cmd_t                cmd_d;
	cmd_t                cmd_s1;
	logic                valid_s1;
	logic [CALC_W-1:0]   first_w;
	logic [CALC_W-1:0]   last_w;
	logic [CALC_W-1:0]   lo_w;
	logic [CALC_W-1:0]   hi_w;
	logic [CALC_W-1:0]   cnt_w;
	logic                range_ok;

	assign first_w = CALC_W'(req.first_block);
	assign last_w  = CALC_W'(req.last_block);
	assign lo_w    = first_w - FDB_C;
	assign hi_w    = last_w - FDB_C;
	assign cnt_w   = CALC_W'(req.request_count);

	assign range_ok = (first_w >= FDB_C) && (last_w >= FDB_C) && (first_w <= last_w)
		&& (hi_w < NUMB_C);

	always_comb begin
		cmd_d            = '0;
		cmd_d.count      = req.request_count;
		cmd_d.count_ok   = (cnt_w != '0) && (cnt_w <= MAXR_C);
		cmd_d.lo         = lo_w[IDX_W-1:0];
		cmd_d.hi         = hi_w[IDX_W-1:0];
		cmd_d.mark_value = req.mark_value;
		case (req.op)
			OP_FIND_SCAT, OP_FIND_CONT: begin
				cmd_d.kind   = CMD_FIND;
				cmd_d.contig = (req.op == OP_FIND_CONT);
			end
			OP_MARK: begin
				cmd_d.kind = range_ok ? CMD_MARK : CMD_REJECT;
			end
			default: begin
				cmd_d.kind = CMD_REJECT;
			end
		endcase
	end

	assign req.ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

[sv/bba_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_cmd_fifo
// Short command queue between the decode front and the scan back end.
// ----------------------------------------------------------------------------
module bba_cmd_fifo
	import bba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t              entry_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (FPTR_W + 1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/bba_back.sv]
`timescale 1ns / 1ps
`include "block_bitmap_allocator_assert.svh"
// ----------------------------------------------------------------------------
// bba_back
// Holds the occupied map, runs the bit-serial search, compaction and marking,
// and drives the result register.
// ----------------------------------------------------------------------------
module bba_back
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  cmd_t     cmd,
	bba_out_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_RESP
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [NUM_BLOCKS-1:0] map_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    end_q;
	logic [IDX_W-1:0]    emit_idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    k_q;
	logic                gap_q;
	logic                prev_free_q;
	logic                retried_q;
	logic                comp_q;
	logic [STAT_W-1:0]   resp_status_q;

	logic                out_valid_q;
	logic [BLK_W-1:0]    out_block_q;
	logic [STAT_W-1:0]   out_status_q;
	logic                out_comp_q;
	logic                out_last_q;

	logic                slot_free;
	logic                out_load;
	logic                bit_occ;
	logic [CNT_W-1:0]    cnt_nx;
	logic [CNT_W-1:0]    k_nx;
	logic                gap_nx;
	logic                hit;
	logic [CALC_W-1:0]   run_start;
	logic [CALC_W-1:0]   emit_blk;
	logic                emit_free;
	logic [NUM_BLOCKS-1:0] mark_map;
	logic [NUM_BLOCKS-1:0] packed_map;

	assign slot_free = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == ST_IDLE);

	// result register takes a new word this cycle
	assign out_load = slot_free
		&& (((state_q == ST_EMIT) && emit_free) || (state_q == ST_RESP));

	// One map bit per scan cycle.
	assign bit_occ = map_q[idx_q];
	assign cnt_nx  = bit_occ ? (cmd_q.contig ? '0 : cnt_q) : cnt_q + 1'b1;
	assign k_nx    = k_q + CNT_W'(bit_occ);
	assign gap_nx  = gap_q || (bit_occ && prev_free_q);
	assign hit     = !bit_occ && cmd_q.count_ok
		&& (CALC_W'(cnt_nx) == CALC_W'(cmd_q.count));
	assign run_start = CALC_W'(idx_q) + 1'b1 - CALC_W'(cmd_q.count);

	assign emit_free = !map_q[emit_idx_q];
	assign emit_blk  = CALC_W'(emit_idx_q) + FDB_C;

	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			mark_map[i]   = ((CALC_W'(i) >= CALC_W'(cmd.lo)) && (CALC_W'(i) <= CALC_W'(cmd.hi)))
				? cmd.mark_value : map_q[i];
			packed_map[i] = (CALC_W'(i) < CALC_W'(k_nx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cmd_q         <= '0;
			map_q         <= '0;
			idx_q         <= '0;
			end_q         <= '0;
			emit_idx_q    <= '0;
			cnt_q         <= '0;
			k_q           <= '0;
			gap_q         <= 1'b0;
			prev_free_q   <= 1'b0;
			retried_q     <= 1'b0;
			comp_q        <= 1'b0;
			resp_status_q <= STAT_OK;
			out_valid_q   <= 1'b0;
			out_block_q   <= '0;
			out_status_q  <= STAT_OK;
			out_comp_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						comp_q      <= 1'b0;
						retried_q   <= 1'b0;
						idx_q       <= '0;
						cnt_q       <= '0;
						k_q         <= '0;
						gap_q       <= 1'b0;
						prev_free_q <= 1'b0;
						case (cmd.kind)
							CMD_FIND: begin
								state_q <= ST_SCAN;
							end
							CMD_MARK: begin
								map_q         <= mark_map;
								resp_status_q <= STAT_OK;
								state_q       <= ST_RESP;
							end
							default: begin
								resp_status_q <= STAT_BAD_RANGE;
								state_q       <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						end_q      <= idx_q;
						emit_idx_q <= cmd_q.contig ? run_start[IDX_W-1:0] : '0;
						state_q    <= ST_EMIT;
					end else if (idx_q == LAST_IDX) begin
						if (cmd_q.contig && !retried_q) begin
							// Retry once, after packing if the map had a hole.
							retried_q   <= 1'b1;
							idx_q       <= '0;
							cnt_q       <= '0;
							k_q         <= '0;
							gap_q       <= 1'b0;
							prev_free_q <= 1'b0;
							if (gap_nx) begin
								map_q  <= packed_map;
								comp_q <= 1'b1;
							end
						end else begin
							resp_status_q <= STAT_NOT_FOUND;
							state_q       <= ST_RESP;
						end
					end else begin
						prev_free_q <= !bit_occ;
						cnt_q       <= cnt_nx;
						k_q         <= k_nx;
						gap_q       <= gap_nx;
						idx_q       <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!emit_free) begin
						emit_idx_q <= emit_idx_q + 1'b1;
					end else if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_block_q  <= emit_blk[BLK_W-1:0];
						out_status_q <= STAT_OK;
						out_comp_q   <= comp_q;
						out_last_q   <= (emit_idx_q == end_q);
						if (emit_idx_q == end_q) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_block_q  <= '0;
						out_status_q <= resp_status_q;
						out_comp_q   <= comp_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.block_number = out_block_q;
	assign rsp.status       = out_status_q;
	assign rsp.compacted    = out_comp_q;
	assign rsp.last_of_run  = out_last_q;

	`BBA_ASSERT_NXT(a_map_hold_emit, clk, arst_n, (state_q == ST_EMIT) || (state_q == ST_RESP), $stable(map_q), "map changed while emitting")
	`BBA_ASSERT_IMP(a_emit_in_run, clk, arst_n, state_q == ST_EMIT, emit_idx_q <= end_q, "emit index ran past end of run")
	`BBA_ASSERT_IMP(a_comp_contig, clk, arst_n, comp_q && (state_q != ST_IDLE), cmd_q.contig && retried_q, "compaction flag without contiguous retry")

endmodule

[sv/block_bitmap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit allocator over a bitmap of data blocks, with contiguous search
// and compaction retry.
// ----------------------------------------------------------------------------
// Keeps one occupied bit for each of NUM_BLOCKS data blocks, numbered from
// FIRST_DATA_BLOCK. A find (scattered or contiguous) answers with the block
// numbers in ascending order, last_of_run on the final word, or one word with
// status "not found"; a contiguous find that misses packs all occupied bits to
// the bottom (compacted set when bits actually moved) and searches once more.
// A mark writes a block range and answers one status word. The back end
// scans the map one bit per cycle, up to NUM_BLOCKS bits per pass and two
// passes for a contiguous retry, then walks map entries while emitting
// (from block zero for a scattered find, from the run start for a
// contiguous one, up to the last block handed out). Each request passes
// through the decode register and command queue before the back end.
// A two-entry command queue lets the front keep taking requests while the
// back end works, and the result register lets the next word be prepared
// while the current one waits on ready. The map resets to all free.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
	import bba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bba_in_if.sink    req,
	bba_out_if.source rsp
);

	// decoded request words, front to queue
	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;

	// queue to back end
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	bba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	bba_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	// search, compaction, marking and result register
	bba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.rsp       (rsp)
	);

endmodule
